// ===== hw/rtl/lobs_pkg.sv =====
// ----------------------------------------------------------------------------
// Largest one-bordered square: shared package
// Types, register indexes and defaults used across the block.
// ----------------------------------------------------------------------------
package lobs_pkg;

    localparam int MAX_ROWS_DEF = 32;
    localparam int MAX_COLS_DEF = 32;

    localparam int DIM_W     = 6;   // row/column counts, runs and sides
    localparam int CFG_IDX_W = 2;
    localparam int STORE_AW  = 16;  // address carried between front and back

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;

    localparam logic [DIM_W-1:0] DIM_RESET = 6'd32;

    typedef struct packed {
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
    } t_job;

    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
        logic                data;
    } t_store_wr;

    typedef enum logic [2:0] {
        B_IDLE,
        B_RUN_RD,
        B_RUN_WR,
        B_SRCH_INIT,
        B_SRCH_RD,
        B_SRCH_EV
    } t_back_state;

endpackage

// ===== hw/rtl/lobs_ifs.sv =====
// ----------------------------------------------------------------------------
// Largest one-bordered square: channel interfaces
// Cell input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface lobs_cell_if;
    logic valid;
    logic ready;
    logic cell_value;
    modport source (output valid, output cell_value, input ready);
    modport sink   (input valid, input cell_value, output ready);
endinterface

interface lobs_side_if;
    logic       valid;
    logic       ready;
    logic [5:0] largest_side;
    modport source (output valid, output largest_side, input ready);
    modport sink   (input valid, input largest_side, output ready);
endinterface

interface lobs_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [5:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/lobs_front.sv =====
// ----------------------------------------------------------------------------
// Largest one-bordered square: front end
// Holds the dimension registers, accepts cells, forwards store writes and
// queues a job when the matrix is complete.
// ----------------------------------------------------------------------------
module lobs_front #(
    parameter int MAX_ROWS = lobs_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = lobs_pkg::MAX_COLS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lobs_cell_if.sink          i_cell,
    lobs_cfg_if.sink           i_cfg,
    input  logic               i_release,
    input  logic               i_q_full,
    output lobs_pkg::t_job     o_job,
    output logic               o_job_push,
    output lobs_pkg::t_store_wr o_wr
);
    import lobs_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int PW    = $clog2(DEPTH + 1);
    localparam int TW    = 2 * DIM_W;
    localparam int CW    = ((PW > TW) ? PW : TW) + 1;

    logic [DIM_W-1:0] r_row_count, r_col_count;
    logic [PW-1:0]    r_pos;
    logic             r_hold;

    logic [DIM_W-1:0] rows, cols;
    logic [TW-1:0]    total;
    logic             accept, last;

    always_comb begin
        if (r_row_count == '0) rows = 6'd1;
        else if (32'(r_row_count) > MAX_ROWS) rows = 6'(MAX_ROWS);
        else rows = r_row_count;
        if (r_col_count == '0) cols = 6'd1;
        else if (32'(r_col_count) > MAX_COLS) cols = 6'(MAX_COLS);
        else cols = r_col_count;
        total = TW'(rows) * TW'(cols);
    end

    assign i_cell.ready = !r_hold && !i_q_full;
    assign i_cfg.ready  = 1'b1;
    assign accept       = i_cell.valid && i_cell.ready;
    assign last         = accept && ((CW'(r_pos) + CW'(1)) >= CW'(total));

    assign o_wr.en    = accept && (32'(r_pos) < DEPTH);
    assign o_wr.addr  = STORE_AW'(r_pos);
    assign o_wr.data  = i_cell.cell_value;
    assign o_job_push = last;
    assign o_job.rows = rows;
    assign o_job.cols = cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= DIM_RESET;
            r_col_count <= DIM_RESET;
            r_pos       <= '0;
            r_hold      <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_ROW_COUNT: r_row_count <= i_cfg.data;
                    REG_COL_COUNT: r_col_count <= i_cfg.data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_pos <= last ? '0 : PW'(r_pos + 1'b1);
            end
            // hold the store until the back end has searched it
            if (last) begin
                r_hold <= 1'b1;
            end else if (i_release) begin
                r_hold <= 1'b0;
            end
        end
    end

endmodule

// ===== hw/rtl/lobs_queue.sv =====
// ----------------------------------------------------------------------------
// Largest one-bordered square: job queue
// Two-entry FIFO of matrix dimensions between front and back.
// ----------------------------------------------------------------------------
module lobs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lobs_pkg::t_job i_job,
    input  logic           i_pop,
    output lobs_pkg::t_job o_job,
    output logic           o_valid,
    output logic           o_full
);
    import lobs_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push_ok, pop_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push_ok) r_wp <= ~r_wp;
            if (pop_ok)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push_ok} - {1'b0, pop_ok};
        end
    end

endmodule

// ===== hw/rtl/lobs_back.sv =====
// ----------------------------------------------------------------------------
// Largest one-bordered square: back end
// Owns the cell and run memories, builds the runs and searches sides.
// ----------------------------------------------------------------------------
module lobs_back #(
    parameter int MAX_ROWS = lobs_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = lobs_pkg::MAX_COLS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lobs_pkg::t_store_wr i_wr,
    input  lobs_pkg::t_job      i_job,
    input  logic                i_job_valid,
    output logic                o_pop,
    output logic                o_release,
    lobs_side_if.source         o_side
);
    import lobs_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic             m_cell  [DEPTH];
    logic [DIM_W-1:0] m_right [DEPTH];
    logic [DIM_W-1:0] m_down  [DEPTH];

    t_back_state r_state, n_state;
    logic [DIM_W-1:0] r_rows, r_cols, r_r, r_c, r_prev, r_s, r_i, r_j, r_side;
    logic [DIM_W-1:0] n_rows, n_cols, n_r, n_c, n_prev, n_s, n_i, n_j, n_side;
    logic [AW-1:0]    r_k, r_tl, r_off, n_k, n_tl, n_off;
    logic             r_out_valid, n_out_valid;

    logic [AW-1:0]    a_cell, a_ra, a_rb, a_da, a_db;
    logic             q_cell;
    logic [DIM_W-1:0] q_ra, q_rb, q_da, q_db;
    logic             w_en;
    logic [DIM_W-1:0] w_right, w_down;
    logic             hit, pop;
    logic [DIM_W-1:0] min_dim;

    assign min_dim = (r_rows < r_cols) ? r_rows : r_cols;
    assign pop     = (r_state == B_IDLE) && i_job_valid && !r_out_valid;
    assign hit     = (q_ra >= r_s) && (q_da >= r_s) && (q_rb >= r_s) && (q_db >= r_s);

    // read addresses
    always_comb begin
        a_cell = r_k;
        a_ra   = r_tl;
        a_rb   = AW'((AW+1)'(r_tl) + (AW+1)'(r_off));
        a_da   = r_tl;
        a_db   = AW'((AW+1)'(r_tl) + (AW+1)'(r_s) - 1'b1);
        if (r_state == B_RUN_RD) begin
            a_db = ((7'(r_r) + 7'd1) < 7'(r_rows)) ?
                   AW'((AW+1)'(r_k) + (AW+1)'(r_cols)) : r_k;
        end
    end

    // run values for the cell at r_k
    always_comb begin
        w_en    = (r_state == B_RUN_WR);
        w_right = '0;
        w_down  = '0;
        if (q_cell) begin
            w_right = ((7'(r_c) + 7'd1) < 7'(r_cols)) ? r_prev + 1'b1 : 6'd1;
            w_down  = ((7'(r_r) + 7'd1) < 7'(r_rows)) ? q_db + 1'b1 : 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) m_cell[AW'(i_wr.addr)] <= i_wr.data;
        q_cell <= m_cell[a_cell];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) m_right[r_k] <= w_right;
        q_ra <= m_right[a_ra];
        q_rb <= m_right[a_rb];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) m_down[r_k] <= w_down;
        q_da <= m_down[a_da];
        q_db <= m_down[a_db];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:      if (pop) n_state = B_RUN_RD;
            B_RUN_RD:    n_state = B_RUN_WR;
            B_RUN_WR:    n_state = (r_k == '0) ? B_SRCH_INIT : B_RUN_RD;
            B_SRCH_INIT: n_state = B_SRCH_RD;
            B_SRCH_RD:   n_state = B_SRCH_EV;
            B_SRCH_EV: begin
                if (hit) n_state = B_IDLE;
                else if ((7'(r_j) + 7'(r_s)) < 7'(r_cols)) n_state = B_SRCH_RD;
                else if ((7'(r_i) + 7'(r_s)) < 7'(r_rows)) n_state = B_SRCH_RD;
                else if (r_s == 6'd1) n_state = B_IDLE;
                else n_state = B_SRCH_INIT;
            end
            default:     n_state = B_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_rows = r_rows; n_cols = r_cols; n_r = r_r; n_c = r_c; n_prev = r_prev;
        n_s = r_s; n_i = r_i; n_j = r_j; n_side = r_side;
        n_k = r_k; n_tl = r_tl; n_off = r_off;
        n_out_valid = r_out_valid && !o_side.ready;
        o_release = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (pop) begin
                    n_rows = i_job.rows;
                    n_cols = i_job.cols;
                    n_r    = i_job.rows - 1'b1;
                    n_c    = i_job.cols - 1'b1;
                    n_k    = AW'(12'(i_job.rows) * 12'(i_job.cols) - 12'd1);
                end
            end
            B_RUN_RD: ;
            B_RUN_WR: begin
                n_prev = w_right;
                n_s    = min_dim;
                if (r_k != '0) begin
                    n_k = r_k - 1'b1;
                    if (r_c == '0) begin
                        n_c = r_cols - 1'b1;
                        n_r = r_r - 1'b1;
                    end else begin
                        n_c = r_c - 1'b1;
                    end
                end
            end
            B_SRCH_INIT: begin
                n_off = AW'(12'(r_s - 1'b1) * 12'(r_cols));
                n_tl  = '0;
                n_i   = '0;
                n_j   = '0;
            end
            B_SRCH_RD: ;
            B_SRCH_EV: begin
                if (hit) begin
                    n_side = r_s; n_out_valid = 1'b1; o_release = 1'b1;
                end else if ((7'(r_j) + 7'(r_s)) < 7'(r_cols)) begin
                    n_j = r_j + 1'b1; n_tl = r_tl + 1'b1;
                end else if ((7'(r_i) + 7'(r_s)) < 7'(r_rows)) begin
                    n_i = r_i + 1'b1; n_j = '0;
                    n_tl = AW'((AW+1)'(r_tl) + (AW+1)'(r_s));
                end else if (r_s == 6'd1) begin
                    n_side = '0; n_out_valid = 1'b1; o_release = 1'b1;
                end else begin
                    n_s = r_s - 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_pop               = pop;
    assign o_side.valid        = r_out_valid;
    assign o_side.largest_side = r_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rows <= n_rows; r_cols <= n_cols; r_r <= n_r; r_c <= n_c; r_prev <= n_prev;
        r_s <= n_s; r_i <= n_i; r_j <= n_j; r_side <= n_side;
        r_k <= n_k; r_tl <= n_tl; r_off <= n_off;
    end

endmodule

// ===== hw/rtl/largest_one_bordered_square.sv =====
// After the last cell beat the back end builds the runs, reading and then writing each
//   cell, then for each tried side reads and evaluates each position until a hit.
// Throughput: one cell beat per cycle while loading; the next matrix loads
//   once the search of the previous one has ended.
// Reset: synchronous, active low; clears dimensions to 32, load position to
//   zero and all handshakes; memories are not cleared.
// ----------------------------------------------------------------------------
// Largest one-bordered square: top level
// Front end loads cells, a job queue decouples it from the back end, which
// builds right/down runs and searches side lengths from the largest down.
// ----------------------------------------------------------------------------
module largest_one_bordered_square #(
    parameter int MAX_ROWS = lobs_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = lobs_pkg::MAX_COLS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lobs_cell_if.sink   i_cell,
    lobs_cfg_if.sink    i_cfg,
    lobs_side_if.source o_side
);
    import lobs_pkg::*;

    t_job      job_in, job_out;
    t_store_wr store_wr;
    logic      job_push, job_pop, job_valid, q_full, release_store;

    // front: dimension registers, cell beats into the store
    lobs_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cell     (i_cell),
        .i_cfg      (i_cfg),
        .i_release  (release_store),
        .i_q_full   (q_full),
        .o_job      (job_in),
        .o_job_push (job_push),
        .o_wr       (store_wr)
    );

    // hold the dimensions of finished matrices until the back end is free
    lobs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (job_pop),
        .o_job   (job_out),
        .o_valid (job_valid),
        .o_full  (q_full)
    );

    // back: run build and side search, result register
    lobs_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (store_wr),
        .i_job       (job_out),
        .i_job_valid (job_valid),
        .o_pop       (job_pop),
        .o_release   (release_store),
        .o_side      (o_side)
    );

endmodule

// ===== hw/rtl/lobs_checker.sv =====
// ----------------------------------------------------------------------------
// Largest one-bordered square: port checker
// Watches the result channel over time.
// ----------------------------------------------------------------------------
module lobs_checker #(
    parameter int MAX_ROWS = lobs_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = lobs_pkg::MAX_COLS_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [5:0] i_out_side
);
    localparam int MAX_SIDE = (MAX_ROWS < MAX_COLS) ? MAX_ROWS : MAX_COLS;

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before taken");

    a_side_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_side))
        else $error("result changed while stalled");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready |=> !i_out_valid)
        else $error("second result without a new matrix");

    a_side_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> 32'(i_out_side) <= MAX_SIDE)
        else $error("side beyond matrix limit");

    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind largest_one_bordered_square lobs_checker #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
) u_lobs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_side.valid),
    .i_out_ready (o_side.ready),
    .i_out_side  (o_side.largest_side)
);

// ===== tb/largest_one_bordered_square_tb.sv =====
// ----------------------------------------------------------------------------
// Largest one-bordered square: testbench
// Streams binary matrices through the cell channel under several row and
// column settings, predicts the largest all-ones-bordered square side of
// each one, and checks every result beat against the prediction in order.
// ----------------------------------------------------------------------------
module largest_one_bordered_square_tb;
    import lobs_pkg::*;

    localparam int STORE_N    = 32 * 32;
    localparam int SETTLE_CYC = 16;

    logic i_clk;
    logic i_rst_n;

    lobs_cell_if cell_ch();
    lobs_cfg_if  cfg_ch();
    lobs_side_if side_ch();

    largest_one_bordered_square dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cell  (cell_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_side  (side_ch.source)
    );

    // Predictor state: its own copy of the registers and the loaded cells.
    logic [DIM_W-1:0] row_reg;
    logic [DIM_W-1:0] col_reg;
    logic [9:0]       load_pos;
    bit               cell_mem [STORE_N];

    logic [DIM_W-1:0] side_q [$];
    int               err_cnt;

    // Sender burst state.
    int burst_left;
    int gap_max;

    // Receiver stall pattern state.
    int stall_mode = 0;
    int stall_cnt  = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Generous fixed cap on the run; the slowest legal run is far below it.
    initial begin
        #40_000_000;
        $display("largest_one_bordered_square test failed");
        $finish;
    end

    function automatic int eff_dim(logic [DIM_W-1:0] v);
        if (v == '0) return 1;
        return (v > 32) ? 32 : int'(v);
    endfunction

    // Build right and down runs, then try sides from the largest down.
    function automatic logic [DIM_W-1:0] square_side(int rows, int cols);
        int rrun [STORE_N];
        int drun [STORE_N];
        int k, tl, bl, tr;
        for (int r = rows - 1; r >= 0; r--) begin
            for (int c = cols - 1; c >= 0; c--) begin
                k = r * cols + c;
                if (cell_mem[k]) begin
                    rrun[k] = (c + 1 < cols) ? rrun[k + 1] + 1 : 1;
                    drun[k] = (r + 1 < rows) ? drun[k + cols] + 1 : 1;
                end else begin
                    rrun[k] = 0;
                    drun[k] = 0;
                end
            end
        end
        for (int s = (rows < cols ? rows : cols); s > 0; s--) begin
            for (int i = 0; i + s <= rows; i++) begin
                for (int j = 0; j + s <= cols; j++) begin
                    tl = i * cols + j;
                    bl = (i + s - 1) * cols + j;
                    tr = i * cols + j + s - 1;
                    if (rrun[tl] >= s && drun[tl] >= s && rrun[bl] >= s && drun[tr] >= s)
                        return DIM_W'(s);
                end
            end
        end
        return '0;
    endfunction

    // Account for one accepted cell; queue a side when the matrix completes.
    task automatic take_cell(bit v);
        int rows, cols;
        rows = eff_dim(row_reg);
        cols = eff_dim(col_reg);
        if (load_pos < STORE_N) cell_mem[load_pos] = v;
        if (int'(load_pos) + 1 >= rows * cols) begin
            load_pos = '0;
            side_q.push_back(square_side(rows, cols));
        end else begin
            load_pos = load_pos + 1'b1;
        end
    endtask

    // Send one cell beat; the sender idles between bursts of random length.
    task automatic send_cell(bit v);
        int gap;
        if (burst_left <= 0) begin
            gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
            if (gap > 0) begin
                cell_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(40, 1);
        end
        burst_left--;
        cell_ch.valid      <= 1'b1;
        cell_ch.cell_value <= v;
        do @(posedge i_clk); while (!cell_ch.ready);
        take_cell(v);
    endtask

    task automatic hold_cells();
        cell_ch.valid <= 1'b0;
        burst_left = 0;
    endtask

    // Hold until every queued side has come back, then let the block settle.
    task automatic drain();
        hold_cells();
        while (side_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_ROW_COUNT) row_reg = val;
        else if (idx == REG_COL_COUNT) col_reg = val;
    endtask

    task automatic set_dims(int rows, int cols);
        write_reg(REG_ROW_COUNT, DIM_W'(rows));
        write_reg(REG_COL_COUNT, DIM_W'(cols));
    endtask

    // Send a whole matrix with the given per-mille chance of a one.
    task automatic send_matrix(int n, int ones_pm);
        for (int i = 0; i < n; i++) send_cell($urandom_range(999, 0) < ones_pm);
    endtask

    // Check each result beat against the oldest predicted side.
    always @(posedge i_clk) begin
        if (i_rst_n && side_ch.valid && side_ch.ready) begin
            if (side_q.size() == 0) begin
                $error("largest_side: unexpected beat, actual %0d", side_ch.largest_side);
                err_cnt++;
            end else begin
                if (side_ch.largest_side !== side_q[0]) begin
                    $error("largest_side: expected %0d actual %0d",
                           side_q[0], side_ch.largest_side);
                    err_cnt++;
                end
                void'(side_q.pop_front());
            end
        end
    end

    // Receiver stall pattern: always ready, coin flip, or one cycle in four.
    always @(posedge i_clk) begin
        if (stall_cnt == 0) begin
            stall_mode <= $urandom_range(2, 0);
            stall_cnt  <= $urandom_range(200, 20);
        end else begin
            stall_cnt <= stall_cnt - 1;
        end
        case (stall_mode)
            0: begin
                side_ch.ready <= 1'b1;
            end
            1: begin
                side_ch.ready <= $urandom_range(1, 0);
            end
            default: begin
                side_ch.ready <= ($urandom_range(3, 0) == 0);
            end
        endcase
    end

    // Smallest case, register zero taken as one, both cell values.
    task automatic test_single_cell();
        set_dims(0, 0);
        send_cell(1'b1);
        send_cell(1'b0);
    endtask

    // Oversized register saturates to the maximum: a 1 x 32 strip.
    task automatic test_saturation();
        set_dims(1, 63);
        send_matrix(32, 1000);
    endtask

    // Full square, hollow square and an empty matrix.
    task automatic test_shapes();
        set_dims(3, 3);
        send_matrix(9, 1000);
        for (int i = 0; i < 9; i++) send_cell(i != 4);
        set_dims(2, 3);
        send_matrix(6, 0);
    endtask

    // Change dimensions in the middle of a load, shrinking and growing.
    task automatic test_resize_midload();
        set_dims(4, 4);
        send_matrix(5, 700);
        // shrink below the load position: the next cell finishes the matrix
        set_dims(2, 2);
        send_cell(1'b1);
        send_matrix(2, 1000);
        // grow: keep the loaded cells and carry on under the new shape
        set_dims(3, 3);
        send_matrix(7, 1000);
    endtask

    // Largest matrix with dense random content.
    task automatic test_max_size();
        set_dims(32, 32);
        send_matrix(STORE_N, 950);
    endtask

    // Mostly well-formed small matrices with random content and shapes.
    task automatic test_random();
        int sent, rows, cols, ones_pm, part;
        int dens [4] = '{500, 800, 950, 1000};
        sent = 0;
        while (sent < 600) begin
            gap_max = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
            if ($urandom_range(19, 0) == 0) begin
                rows = $urandom_range(32, 9);
                cols = $urandom_range(12, 1);
            end else begin
                rows = $urandom_range(8, 1);
                cols = $urandom_range(8, 1);
            end
            if ($urandom_range(9, 0) == 0) set_dims(0, $urandom_range(63, 33));
            else set_dims(rows, cols);
            rows = eff_dim(row_reg);
            cols = eff_dim(col_reg);
            ones_pm = dens[$urandom_range(3, 0)];
            if ($urandom_range(9, 0) == 0) begin
                // broken sequence: reshape part-way through a load
                part = $urandom_range(rows * cols - 1, 0);
                send_matrix(part, ones_pm);
                sent += part;
                set_dims($urandom_range(6, 1), $urandom_range(6, 1));
                part = eff_dim(row_reg) * eff_dim(col_reg) - int'(load_pos);
                if (part < 1) part = 1;
                send_matrix(part, ones_pm);
                sent += part;
            end else begin
                send_matrix(rows * cols, ones_pm);
                sent += rows * cols;
            end
        end
    endtask

    initial begin
        int wait_cyc;
        err_cnt    = 0;
        row_reg    = DIM_RESET;
        col_reg    = DIM_RESET;
        load_pos   = '0;
        burst_left = 0;
        gap_max    = 3;
        i_rst_n            <= 1'b0;
        cell_ch.valid      <= 1'b0;
        cell_ch.cell_value <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= REG_ROW_COUNT;
        cfg_ch.data        <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_cell();
        test_saturation();
        test_shapes();
        test_resize_midload();
        test_max_size();
        test_random();

        // Wait out the remaining results, bounded by a worst-case search.
        hold_cells();
        wait_cyc = 0;
        while (side_q.size() != 0 && wait_cyc < 200_000) begin
            @(posedge i_clk);
            wait_cyc++;
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (err_cnt == 0 && side_q.size() == 0) begin
            $display("largest_one_bordered_square test passed");
        end else begin
            if (side_q.size() != 0)
                $error("largest_side: %0d expected beats never came", side_q.size());
            $display("largest_one_bordered_square test failed");
        end
        $finish;
    end

endmodule
